// ===== design/stsu_pkg.sv =====
// Package for the sparse triplet row/column sorter.
// Holds widths, defaults, the packed entry type, the action codes and the sort key.
package stsu_pkg;

   localparam int DefMaxEntries = 1024;
   localparam int DefMaxRows    = 65536;
   localparam int RowWidth      = 16;
   localparam int ColWidth      = 16;
   localparam int ValWidth      = 64;
   localparam int PosWidth      = 10;
   localparam int EntryWidth    = RowWidth + ColWidth + ValWidth;

   // Action codes carried in tuser.
   localparam logic ActLoad  = 1'b0;
   localparam logic ActDrain = 1'b1;

   typedef struct packed {
      logic [ValWidth-1:0] value_bits;
      logic [ColWidth-1:0] col;
      logic [RowWidth-1:0] row;
   } entry_type;

   // Sort key: row in the upper half, column in the lower half.
   function automatic logic [RowWidth+ColWidth-1:0] key_of(input entry_type e);
      return {e.row, e.col};
   endfunction

endpackage

// ===== design/stsu_store.sv =====
// Entry store of the sorter: one synchronous memory, one write and one read port.
// Depends on stsu_pkg for the entry type.
module stsu_store
   import stsu_pkg::*;
#(
   parameter int MaxEntries = DefMaxEntries,
   parameter int AddrWidth  = $clog2(MaxEntries)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  entry_type            wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output entry_type            rd_data
);

   entry_type mem [MaxEntries];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sparse_triplet_row_col_sorter_unit.sv =====
// Top level of the sparse triplet sorter: control sequencer and output register.
// Depends on stsu_pkg and stsu_store.
//
// Loads (tuser = 0) insert an entry into a store that is always kept sorted by
// row and then column, ties in arrival order. A load walks down from the end of
// the store, reading one entry a cycle and writing it back one place higher
// until it finds the insertion point, then writes the new entry into the freed
// slot; at the front of the store the walk ends without a final compare. A load
// that finds the store empty, or whose entry is dropped, is done in the idle
// state. A drain (tuser = 1) reads the next sorted entry in two reads of the
// single read port (the previous entry, for the row-first flag, and the entry
// itself), then hands it to the output register. Loads and drains
// are handled one at a time. The result sits in an output register, so the next
// request is taken while a result waits. A drain that ends while an earlier
// result still waits holds in its last step until the output register frees.
module sparse_triplet_row_col_sorter_unit
   import stsu_pkg::*;
#(
   parameter int MaxEntries = DefMaxEntries,
   parameter int MaxRows    = DefMaxRows
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // row[15:0], col[31:16], value_bits[95:32]
   input  logic         req_tuser,  // action
   input  logic         req_tlast,  // load_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // out_row, out_col, out_value_bits, position,
                                    // row_first, overflow, zero fill
   output logic         rsp_tlast   // out_last
);

   localparam int AddrWidth = $clog2(MaxEntries);
   localparam int CntWidth  = $clog2(MaxEntries + 1);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StIRead = 3'd1;
   localparam logic [2:0] StIChk  = 3'd2;
   localparam logic [2:0] StDPrev = 3'd3;
   localparam logic [2:0] StDCur  = 3'd4;
   localparam logic [2:0] StDOut  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] rdidx_ff, rdidx_in;
   logic [CntWidth-1:0] pos_ff, pos_in;
   logic                sorted_ff, sorted_in;
   logic                ovf_ff, ovf_in;
   entry_type           new_ff, new_in;
   logic [RowWidth-1:0] prev_row_ff, prev_row_in;
   logic                out_valid_ff, out_valid_in;
   entry_type           out_e_ff, out_e_in;
   logic [PosWidth-1:0] out_pos_ff, out_pos_in;
   logic                out_first_ff, out_first_in;
   logic                out_last_ff, out_last_in;
   logic                out_ovf_ff, out_ovf_in;

   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   entry_type            wr_data, rd_data;
   entry_type            req_e;
   logic                 req_acc;
   logic [CntWidth-1:0]  cnt_eff;
   logic                 can_out;

   assign req_e.row        = req_tdata[15:0];
   assign req_e.col        = req_tdata[31:16];
   assign req_e.value_bits = req_tdata[95:32];
   assign can_out    = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == StIdle);
   assign req_acc    = req_tvalid && req_tready;

   stsu_store #(.MaxEntries(MaxEntries), .AddrWidth(AddrWidth)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Sequencer: insertion walk for loads, two reads for drains.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rdidx_in     = rdidx_ff;
      pos_in       = pos_ff;
      sorted_in    = sorted_ff;
      ovf_in       = ovf_ff;
      new_in       = new_ff;
      prev_row_in  = prev_row_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_e_in     = out_e_ff;
      out_pos_in   = out_pos_ff;
      out_first_in = out_first_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AddrWidth-1:0];
      wr_data      = new_ff;
      rd_addr      = pos_ff[AddrWidth-1:0] - AddrWidth'(1);
      cnt_eff      = sorted_ff ? '0 : count_ff;
      case (state_ff)
         StIdle: begin
            if (req_acc && req_tuser == ActLoad) begin
               if (sorted_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
               sorted_in = req_tlast;
               rdidx_in  = '0;
               if ({9'd0, req_e.row} >= 25'(MaxRows) ||
                   cnt_eff >= CntWidth'(MaxEntries)) begin
                  ovf_in = 1'b1;
               end else if (cnt_eff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_e;
                  count_in = CntWidth'(1);
               end else begin
                  new_in   = req_e;
                  pos_in   = cnt_eff;
                  count_in = cnt_eff;
                  rd_addr  = cnt_eff[AddrWidth-1:0] - AddrWidth'(1);
                  state_in = StIChk;
               end
            end else if (req_acc) begin
               if (sorted_ff && count_ff != '0) begin
                  pos_in   = (rdidx_ff >= count_ff) ? '0 : rdidx_ff;
                  state_in = StDPrev;
               end
            end
         end
         StIChk: begin
            // rd_data holds entry pos-1.
            if (key_of(rd_data) > key_of(new_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - CntWidth'(1);
               if (pos_ff == CntWidth'(1)) begin
                  state_in = StIRead;
               end else begin
                  rd_addr = pos_ff[AddrWidth-1:0] - AddrWidth'(2);
               end
            end else begin
               state_in = StIRead;
            end
         end
         StIRead: begin
            // Place the new entry at its slot.
            wr_en    = 1'b1;
            count_in = count_ff + CntWidth'(1);
            state_in = StIdle;
         end
         StDPrev: begin
            state_in = StDCur;
         end
         StDCur: begin
            prev_row_in = rd_data.row;
            rd_addr     = pos_ff[AddrWidth-1:0];
            state_in    = StDOut;
         end
         StDOut: begin
            // Keep reading the entry so it stays on rd_data while the output waits.
            rd_addr = pos_ff[AddrWidth-1:0];
            if (can_out) begin
               out_valid_in = 1'b1;
               out_e_in     = rd_data;
               out_pos_in   = PosWidth'(pos_ff);
               out_first_in = (pos_ff == '0) || (prev_row_ff != rd_data.row);
               out_last_in  = (pos_ff + CntWidth'(1) == count_ff);
               out_ovf_in   = ovf_ff;
               rdidx_in     = out_last_in ? '0 : pos_ff + CntWidth'(1);
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         rdidx_ff     <= '0;
         sorted_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rdidx_ff     <= rdidx_in;
         sorted_ff    <= sorted_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      new_ff       <= new_in;
      prev_row_ff  <= prev_row_in;
      out_e_ff     <= out_e_in;
      out_pos_ff   <= out_pos_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ovf_ff, out_first_ff, out_pos_ff,
                        out_e_ff.value_bits, out_e_ff.col, out_e_ff.row};
   assign rsp_tlast  = out_last_ff;

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(MaxEntries))
      else $error("entry count above depth");

   // Requests are only taken in the idle state.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == StIdle)
      else $error("ready outside idle");

   // A drain walk ends with a result in the output register.
   a_drain_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDOut && can_out) |=> rsp_tvalid)
      else $error("drain produced no result");

   // A held result keeps its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

// ===== tb/sparse_triplet_row_col_sorter_unit_tb.sv =====
// Testbench for the sparse triplet row/column sorter: loads entry sets, drains them
// sorted, and checks every drained transaction against a built-in predictor.
// Depends on stsu_pkg and the sorter RTL.
`timescale 1ns / 100ps

module sparse_triplet_row_col_sorter_unit_tb
   import stsu_pkg::*;
();

   localparam int  Depth  = DefMaxEntries;
   localparam int  MaxCyc = 4000000;

   typedef struct packed {
      logic        action;
      logic [15:0] row;
      logic [15:0] col;
      logic [63:0] val;
      logic        last;
   } request_type;

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] col;
      logic [63:0] val;
      logic [9:0]  pos;
      logic        first;
      logic        last;
      logic        ovf;
   } sorted_entry_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [111:0]  rsp_tdata;
   logic          rsp_tlast;

   request_type      pending_q[$];
   sorted_entry_type expected_q[$];
   int            mismatches = 0;
   int            drained = 0;
   int            loads_sent = 0;
   int            sent = 0;
   int            cycles = 0;
   bit            req_taken = 1'b0;
   bit            calm = 1'b0;

   // Predictor state: a store kept in sorted order.
   logic [15:0]   st_row[Depth];
   logic [15:0]   st_col[Depth];
   logic [63:0]   st_val[Depth];
   int            st_count = 0;
   int            rd_idx = 0;
   bit            set_closed = 1'b0;
   bit            set_ovf = 1'b0;

   sparse_triplet_row_col_sorter_unit DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Predict the outcome of one accepted request transaction.
   task automatic predict_sorted(input request_type r);
      int p;
      sorted_entry_type e;
      if (r.action == ActLoad) begin
         if (set_closed) begin
            st_count = 0; rd_idx = 0; set_ovf = 0; set_closed = 0;
         end
         if (st_count >= Depth || int'(r.row) >= DefMaxRows) set_ovf = 1;
         else begin
            p = st_count;
            while (p > 0 && {st_row[p-1], st_col[p-1]} > {r.row, r.col}) begin
               st_row[p] = st_row[p-1]; st_col[p] = st_col[p-1];
               st_val[p] = st_val[p-1];
               p--;
            end
            st_row[p] = r.row; st_col[p] = r.col; st_val[p] = r.val;
            st_count++;
         end
         if (r.last) begin
            set_closed = 1; rd_idx = 0;
         end
      end else if (set_closed && st_count != 0) begin
         if (rd_idx >= st_count) rd_idx = 0;
         e.row   = st_row[rd_idx];
         e.col   = st_col[rd_idx];
         e.val   = st_val[rd_idx];
         e.pos   = rd_idx[9:0];
         e.first = (rd_idx == 0) || (st_row[rd_idx-1] != st_row[rd_idx]);
         e.last  = (rd_idx + 1 == st_count);
         e.ovf   = set_ovf;
         expected_q.push_back(e);
         rd_idx  = e.last ? 0 : rd_idx + 1;
      end
   endtask

   // Driver: presents queued transactions, with random gaps.
   always @(negedge clock) begin
      request_type r;
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold the current transaction
         end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
            r = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= r.action;
            req_tdata  <= {r.val, r.col, r.row};
            req_tlast  <= r.last;
            predict_sorted(r);
         end else begin
            req_tvalid <= 1'b0;
            req_tdata  <= {$urandom, $urandom, $urandom};
         end
         rsp_tready <= calm || ($urandom_range(99) >= 11);
      end
   end

   // Monitor: records accepted requests and compares each drained transaction
   // with the oldest expectation.
   always @(posedge clock) begin
      sorted_entry_type e;
      sorted_entry_type got;
      if (!reset) begin
         cycles    <= cycles + 1;
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) sent <= sent + 1;
         if (req_tvalid && req_tready && req_tuser == ActLoad) loads_sent <= loads_sent + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = '{row: rsp_tdata[15:0], col: rsp_tdata[31:16],
                    val: rsp_tdata[95:32], pos: rsp_tdata[105:96],
                    first: rsp_tdata[106], last: rsp_tlast, ovf: rsp_tdata[107]};
            drained <= drained + 1;
            if (expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("Unexpected result transaction: %p", got);
            end else begin
               e = expected_q.pop_front();
               if (e !== got) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) $display("Mismatch: expected %p, got %p", e, got);
               end
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycles > MaxCyc) begin
         $display("sparse_triplet_row_col_sorter_unit test failed");
         $finish;
      end
   end

   function automatic request_type load_item(input logic [15:0] r, input logic [15:0] c,
                                             input bit lst);
      request_type q;
      q.action = ActLoad; q.row = r; q.col = c;
      q.val = {$urandom, $urandom}; q.last = lst;
      return q;
   endfunction

   function automatic request_type drain_item();
      request_type q;
      q.action = ActDrain; q.row = 16'($urandom); q.col = 16'($urandom);
      q.val = {$urandom, $urandom}; q.last = 1'($urandom_range(1));
      return q;
   endfunction

   // Random set: mostly small clustered keys so rows repeat and ties occur.
   task automatic queue_set(input int n, input int ndrain);
      logic [15:0] r;
      logic [15:0] c;
      for (int i = 0; i < n; i++) begin
         r = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
         c = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
         pending_q.push_back(load_item(r, c, i == n - 1));
      end
      for (int i = 0; i < ndrain; i++) pending_q.push_back(drain_item());
   endtask

   initial begin
      int n;
      request_type q;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: drain with nothing loaded, extremes, ties, wrap past the end.
      pending_q.push_back(drain_item());
      pending_q.push_back(load_item(16'hFFFF, 16'hFFFF, 0));
      pending_q.push_back(drain_item());
      pending_q.push_back(load_item(16'h0000, 16'h0000, 0));
      q = load_item(16'hFFFF, 16'h0000, 0); q.val = '1; pending_q.push_back(q);
      q = load_item(16'h0000, 16'h0000, 0); q.val = '0; pending_q.push_back(q);
      pending_q.push_back(load_item(16'h5555, 16'hAAAA, 0));
      pending_q.push_back(load_item(16'hAAAA, 16'h5555, 1));
      repeat (7) pending_q.push_back(drain_item());
      pending_q.push_back(load_item(16'h0001, 16'h0002, 1));
      repeat (2) pending_q.push_back(drain_item());

      // Random sets of mostly small sizes, with stray drains as noise.
      calm = 1'b0;
      while (sent + pending_q.size() < 480) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         queue_set(n, $urandom_range(n / 2, n + 3));
         if ($urandom_range(5) == 0) pending_q.push_back(drain_item());
         wait (pending_q.size() < 100);
      end
      wait (pending_q.size() == 0);

      // One full store, mostly without idling, then two dropped entries.
      calm = 1'b1;
      for (int i = 0; i < Depth; i++)
         pending_q.push_back(load_item(16'($urandom_range(63)), 16'($urandom), 0));
      wait (pending_q.size() < 10);
      calm = 1'b0;
      pending_q.push_back(load_item(16'h1234, 16'h4321, 0));
      pending_q.push_back(load_item(16'h0000, 16'h0000, 1));
      repeat (40) pending_q.push_back(drain_item());
      queue_set(5, 6);

      wait (pending_q.size() == 0 && !(req_tvalid && !req_taken));
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d load transactions in sets up to the full store, and %0d sorted",
               loads_sent, drained);
      $display("results including wraparound, ties, extreme keys and overflow.");
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("sparse_triplet_row_col_sorter_unit test passed");
      end else begin
         $display("sparse_triplet_row_col_sorter_unit test failed");
      end
      $finish;
   end

endmodule
